[rtl/bgms_pkg.sv]
// Package of the barrier gate motor sequencer: codes, stage type and the structs
// shared by the sequencer control and the top level.
// Depends on nothing.
package bgms_pkg;

  localparam int TICK_COUNT_WIDTH = 16;

  // Request kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_MOTOR = 2'd2;

  // Motor direction codes; the fourth code is treated as stop.
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_PWM_PERIOD  = 3'd0;
  localparam logic [2:0] REG_GATE_DUTY   = 3'd1;
  localparam logic [2:0] REG_OPEN_MS     = 3'd2;
  localparam logic [2:0] REG_HOLD_MS     = 3'd3;
  localparam logic [2:0] REG_WAIT_MAX_MS = 3'd4;
  localparam logic [2:0] REG_CLOSE_MS    = 3'd5;

  // Register reset values.
  localparam logic [15:0] PWM_PERIOD_RST  = 16'd4200;
  localparam logic [6:0]  GATE_DUTY_RST   = 7'd50;
  localparam logic [15:0] OPEN_MS_RST     = 16'd2000;
  localparam logic [15:0] HOLD_MS_RST     = 16'd1000;
  localparam logic [15:0] WAIT_MAX_MS_RST = 16'd10000;
  localparam logic [15:0] CLOSE_MS_RST    = 16'd2000;

  localparam logic [6:0] DUTY_FULL = 7'd100;
  localparam logic [5:0] ROUND_HALF = 6'd50;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_OPENING = 3'd1,
    ST_HOLD    = 3'd2,
    ST_WAITING = 3'd3,
    ST_CLOSING = 3'd4
  } stage_e;

  typedef struct packed {
    logic [15:0] pwm_period;
    logic [6:0]  gate_duty;
    logic [15:0] open_ms;
    logic [15:0] hold_ms;
    logic [15:0] wait_max_ms;
    logic [15:0] close_ms;
  } cfg_t;

  // Outcome of one request, before the compare values are scaled.
  typedef struct packed {
    logic       drv_req;   // request touched the motor drive
    logic       drv_stop;  // drive ended in stop, both compares zero
    logic [1:0] dir;       // present direction after the request
    logic [6:0] duty;      // clamped duty of the drive
    logic       blank;
    logic       busy;
    logic       waiting;
    logic       done;
    logic       timeout;
  } step_res_t;

endpackage

[rtl/barrier_gate_motor_sequencer_unit.sv]
// Top level of the barrier gate motor sequencer: configuration registers,
// request pipeline and the compare scaling. Depends on bgms_pkg, bgms_ctrl
// and bgms_div100.
//
// Usage. Requests arrive on the in channel (valid/ready); each one is a
// millisecond tick, a gate start or a direct motor command, and each gives
// exactly one result on the out channel (valid/ready), in order.
// The configuration channel writes one of six registers by index; it is
// always ready and should only be used while no request is in flight.
// A request is loaded into the input register when accepted, then into the
// step register with the sequencer step and the period-times-duty product,
// and then into the output register through the reciprocal divide by one
// hundred, which raises out_valid_o.
// Throughput is one request per cycle while the receiver takes each result.
// The pipeline is the only limit: each stage takes a new request when it is
// empty or its successor moves on. When the receiver stalls, the output
// register holds its result and the stages behind it keep filling, so up to
// two further requests are taken before in_ready_o drops.
// Reset clears the pipeline, the gate stage (idle), the direction (stop),
// both flags and both compare outputs, and loads the register defaults.
module barrier_gate_motor_sequencer_unit
  import bgms_pkg::*;
#(
  parameter int TickCountWidth = TICK_COUNT_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic        path_occupied_i,
  input  logic [1:0]  motor_direction_i,
  input  logic [6:0]  duty_pct_i,
  input  logic        take_done_i,
  input  logic        take_timeout_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] ch1_compare_o,
  output logic [15:0] ch2_compare_o,
  output logic [1:0]  drive_direction_o,
  output logic        reversal_blank_o,
  output logic        busy_res_o,
  output logic        waiting_clear_o,
  output logic        done_flag_o,
  output logic        timeout_flag_o
);

  cfg_t cfg_q;

  // Input register.
  logic       r0_valid_q;
  logic [1:0] r0_kind_q;
  logic       r0_blocked_q;
  logic [1:0] r0_mdir_q;
  logic [6:0] r0_duty_q;
  logic       r0_take_done_q;
  logic       r0_take_timeout_q;

  // Step register: sequencer outcome plus the rounded product.
  logic        s1_valid_q;
  step_res_t   s1_res_q;
  step_res_t   step_res;
  logic [22:0] s1_prod_q, prod_d;

  // Output register.
  logic        out_valid_q;
  logic [15:0] ch1_q, ch2_q;
  logic [1:0]  dir_q;
  logic        blank_q, busy_q, waiting_q, done_q, timeout_q;

  logic        out_load, s1_load, r0_load;
  logic        out_free, s1_free, r0_free;
  logic [15:0] quotient;

  // Each stage frees up when it is empty or its content moves on.
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_free  = !s1_valid_q || out_free;
  assign r0_free  = !r0_valid_q || s1_free;
  assign out_load = s1_valid_q && out_free;
  assign s1_load  = r0_valid_q && s1_free;
  assign r0_load  = in_valid_i && r0_free;

  assign in_ready_o  = r0_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period  <= PWM_PERIOD_RST;
      cfg_q.gate_duty   <= GATE_DUTY_RST;
      cfg_q.open_ms     <= OPEN_MS_RST;
      cfg_q.hold_ms     <= HOLD_MS_RST;
      cfg_q.wait_max_ms <= WAIT_MAX_MS_RST;
      cfg_q.close_ms    <= CLOSE_MS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PWM_PERIOD:  cfg_q.pwm_period  <= cfg_data_i;
        REG_GATE_DUTY:   cfg_q.gate_duty   <= cfg_data_i[6:0];
        REG_OPEN_MS:     cfg_q.open_ms     <= cfg_data_i;
        REG_HOLD_MS:     cfg_q.hold_ms     <= cfg_data_i;
        REG_WAIT_MAX_MS: cfg_q.wait_max_ms <= cfg_data_i;
        REG_CLOSE_MS:    cfg_q.close_ms    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (r0_free) begin
        r0_valid_q <= in_valid_i;
      end
      if (s1_free) begin
        s1_valid_q <= r0_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r0_load) begin
      r0_kind_q         <= kind_i;
      r0_blocked_q      <= path_occupied_i;
      r0_mdir_q         <= motor_direction_i;
      r0_duty_q         <= duty_pct_i;
      r0_take_done_q    <= take_done_i;
      r0_take_timeout_q <= take_timeout_i;
    end
  end

  bgms_ctrl #(
    .TickCountWidth(TickCountWidth)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (s1_load),
    .kind_i           (r0_kind_q),
    .path_occupied_i  (r0_blocked_q),
    .motor_direction_i(r0_mdir_q),
    .duty_pct_i       (r0_duty_q),
    .take_done_i      (r0_take_done_q),
    .take_timeout_i   (r0_take_timeout_q),
    .cfg_i            (cfg_q),
    .res_o            (step_res)
  );

  // Period times clamped duty plus half of one hundred, for rounding; the
  // largest value is 65535 * 100 + 50, which fits in 23 bits.
  assign prod_d = {7'b0, cfg_q.pwm_period} * {16'b0, step_res.duty} + {17'b0, ROUND_HALF};

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_res_q  <= step_res;
      s1_prod_q <= prod_d;
    end
  end

  bgms_div100 u_div100 (
    .dividend_i(s1_prod_q),
    .quotient_o(quotient)
  );

  // The compare outputs keep their value across requests that leave the
  // drive alone, so they reset like the rest of the control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch1_q <= '0;
      ch2_q <= '0;
    end else if (out_load && s1_res_q.drv_req) begin
      if (s1_res_q.drv_stop) begin
        ch1_q <= '0;
        ch2_q <= '0;
      end else if (s1_res_q.dir == DIR_CW) begin
        ch1_q <= '0;
        ch2_q <= quotient;
      end else begin
        ch1_q <= quotient;
        ch2_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dir_q     <= s1_res_q.dir;
      blank_q   <= s1_res_q.blank;
      busy_q    <= s1_res_q.busy;
      waiting_q <= s1_res_q.waiting;
      done_q    <= s1_res_q.done;
      timeout_q <= s1_res_q.timeout;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ch1_compare_o     = ch1_q;
  assign ch2_compare_o     = ch2_q;
  assign drive_direction_o = dir_q;
  assign reversal_blank_o  = blank_q;
  assign busy_res_o        = busy_q;
  assign waiting_clear_o   = waiting_q;
  assign done_flag_o       = done_q;
  assign timeout_flag_o    = timeout_q;

endmodule

[rtl/bgms_div100.sv]
// Divide by one hundred by reciprocal multiply; exact for inputs below 6553600.
// Depends on nothing.
module bgms_div100 (
  input  logic [22:0] dividend_i,
  output logic [15:0] quotient_o
);

  // ceil(2^30 / 100); the error stays below one part in a hundred for all
  // inputs under 2^23.
  localparam logic [23:0] Recip = 24'd10737419;

  logic [46:0] prod;

  assign prod       = {24'b0, dividend_i} * {23'b0, Recip};
  assign quotient_o = prod[45:30];

endmodule

[rtl/bgms_ctrl.sv]
// Gate sequence state machine, elapsed counter, drive direction and flags.
// Depends on bgms_pkg.
module bgms_ctrl
  import bgms_pkg::*;
#(
  parameter int TickCountWidth = TICK_COUNT_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] kind_i,
  input  logic       path_occupied_i,
  input  logic [1:0] motor_direction_i,
  input  logic [6:0] duty_pct_i,
  input  logic       take_done_i,
  input  logic       take_timeout_i,
  input  cfg_t       cfg_i,
  output step_res_t  res_o
);

  localparam int CmpW = (TickCountWidth > 16) ? TickCountWidth : 16;

  stage_e                    stage_q, stage_d;
  logic [TickCountWidth-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [1:0]                dir_q, dir_d;
  logic                      done_q, done_d, timeout_q, timeout_d;
  logic [CmpW-1:0]           el_ext;
  logic                      open_hit, hold_hit, wait_hit, close_hit;
  logic                      drv_req;
  logic [1:0]                drv_dir;
  logic [6:0]                drv_duty, duty_c;
  logic                      drv_stop, blank;

  // Saturating count, compared at the wider of the two widths so that a
  // limit above the saturation value is never reached.
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign el_ext      = CmpW'(elapsed_inc);
  assign open_hit    = el_ext >= CmpW'(cfg_i.open_ms);
  assign hold_hit    = el_ext >= CmpW'(cfg_i.hold_ms);
  assign wait_hit    = el_ext >= CmpW'(cfg_i.wait_max_ms);
  assign close_hit   = el_ext >= CmpW'(cfg_i.close_ms);

  always_comb begin
    stage_d   = stage_q;
    elapsed_d = elapsed_q;
    done_d    = done_q;
    timeout_d = timeout_q;
    drv_req   = 1'b0;
    drv_dir   = DIR_STOP;
    drv_duty  = '0;
    unique case (kind_i)
      KIND_TICK: begin
        elapsed_d = elapsed_inc;
        unique case (stage_q)
          ST_OPENING: begin
            if (open_hit) begin
              stage_d   = ST_HOLD;
              elapsed_d = '0;
              drv_req   = 1'b1;
            end
          end
          ST_HOLD: begin
            if (hold_hit) begin
              stage_d   = ST_WAITING;
              elapsed_d = '0;
            end
          end
          ST_WAITING: begin
            if (!path_occupied_i || wait_hit) begin
              if (path_occupied_i) begin
                timeout_d = 1'b1;
              end
              stage_d   = ST_CLOSING;
              elapsed_d = '0;
              drv_req   = 1'b1;
              drv_dir   = DIR_CW;
              drv_duty  = cfg_i.gate_duty;
            end
          end
          ST_CLOSING: begin
            if (close_hit) begin
              stage_d = ST_IDLE;
              drv_req = 1'b1;
              done_d  = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      KIND_START: begin
        stage_d   = ST_OPENING;
        elapsed_d = '0;
        done_d    = 1'b0;
        timeout_d = 1'b0;
        drv_req   = 1'b1;
        drv_dir   = DIR_CCW;
        drv_duty  = cfg_i.gate_duty;
      end
      KIND_MOTOR: begin
        drv_req  = 1'b1;
        drv_dir  = motor_direction_i;
        drv_duty = duty_pct_i;
      end
      default: begin
      end
    endcase
  end

  // Drive: clamp duty, a zero duty or unknown direction stops the motor, and
  // switching between the two running directions raises the blank pulse.
  always_comb begin
    duty_c   = (drv_duty > DUTY_FULL) ? DUTY_FULL : drv_duty;
    drv_stop = ((drv_dir != DIR_CW) && (drv_dir != DIR_CCW)) || (duty_c == '0);
    dir_d    = dir_q;
    blank    = 1'b0;
    if (drv_req) begin
      if (drv_stop) begin
        dir_d = DIR_STOP;
      end else begin
        blank = (dir_q != DIR_STOP) && (dir_q != drv_dir);
        dir_d = drv_dir;
      end
    end
  end

  always_comb begin
    res_o.drv_req  = drv_req;
    res_o.drv_stop = drv_stop;
    res_o.dir      = dir_d;
    res_o.duty     = duty_c;
    res_o.blank    = blank;
    res_o.busy     = stage_d != ST_IDLE;
    res_o.waiting  = stage_d == ST_WAITING;
    res_o.done     = done_d;
    res_o.timeout  = timeout_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q   <= ST_IDLE;
      elapsed_q <= '0;
      dir_q     <= DIR_STOP;
      done_q    <= 1'b0;
      timeout_q <= 1'b0;
    end else if (step_i) begin
      stage_q   <= stage_d;
      elapsed_q <= elapsed_d;
      dir_q     <= dir_d;
      done_q    <= done_d & ~take_done_i;
      timeout_q <= timeout_d & ~take_timeout_i;
    end
  end

endmodule
